FILE: rtl/ssc_pkg.sv
// Shared types, register indexes and commutation tables for the six-step commutator.
// No dependencies; every other file in rtl/ imports this package.
package ssc_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int RC_CFG_W    = 16;
    localparam int SHIFT_W     = 4;
    localparam int FLOOR_W     = 8;
    localparam int PRESCALE_CFG_W = 9;
    localparam int PRESCALE_W  = 8;
    localparam int PRESCALE_MAX = 256;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
    typedef logic [2:0]             step_t;

    localparam cfg_index_t CFG_RC_MIN       = 3'd0;
    localparam cfg_index_t CFG_RC_MAX       = 3'd1;
    localparam cfg_index_t CFG_DUTY_SHIFT   = 3'd2;
    localparam cfg_index_t CFG_DUTY_FLOOR   = 3'd3;
    localparam cfg_index_t CFG_PWM_PRESCALE = 3'd4;

    localparam logic [RC_CFG_W-1:0]       RC_MIN_RESET       = 16'd16000;
    localparam logic [RC_CFG_W-1:0]       RC_MAX_RESET       = 16'd32000;
    localparam logic [SHIFT_W-1:0]        DUTY_SHIFT_RESET   = 4'd8;
    localparam logic [FLOOR_W-1:0]        DUTY_FLOOR_RESET   = 8'd1;
    localparam logic [PRESCALE_CFG_W-1:0] PWM_PRESCALE_RESET = 9'd8;

    localparam step_t STEP_0 = 3'd0;
    localparam step_t STEP_1 = 3'd1;
    localparam step_t STEP_2 = 3'd2;
    localparam step_t STEP_3 = 3'd3;
    localparam step_t STEP_4 = 3'd4;
    localparam step_t STEP_5 = 3'd5;
    localparam step_t STEP_LAST = STEP_5;

    typedef enum logic [1:0] {
        PHASE_A = 2'd0,
        PHASE_B = 2'd1,
        PHASE_C = 2'd2
    } phase_t;

    function automatic phase_t step_high(input step_t s);
        phase_t p;
        case (s)
            STEP_0:  p = PHASE_B;
            STEP_1:  p = PHASE_A;
            STEP_2:  p = PHASE_A;
            STEP_3:  p = PHASE_C;
            STEP_4:  p = PHASE_C;
            STEP_5:  p = PHASE_B;
            default: p = PHASE_A;
        endcase
        return p;
    endfunction

    function automatic phase_t step_low(input step_t s);
        phase_t p;
        case (s)
            STEP_0:  p = PHASE_C;
            STEP_1:  p = PHASE_C;
            STEP_2:  p = PHASE_B;
            STEP_3:  p = PHASE_B;
            STEP_4:  p = PHASE_A;
            STEP_5:  p = PHASE_A;
            default: p = PHASE_A;
        endcase
        return p;
    endfunction

    function automatic phase_t step_sense(input step_t s);
        phase_t p;
        case (s)
            STEP_0:  p = PHASE_A;
            STEP_1:  p = PHASE_B;
            STEP_2:  p = PHASE_C;
            STEP_3:  p = PHASE_A;
            STEP_4:  p = PHASE_B;
            STEP_5:  p = PHASE_C;
            default: p = PHASE_A;
        endcase
        return p;
    endfunction

    // Comparator level that ends each step; the zero crossing alternates direction.
    function automatic logic step_wait(input step_t s);
        logic w;
        case (s)
            STEP_0:  w = 1'b1;
            STEP_1:  w = 1'b0;
            STEP_2:  w = 1'b1;
            STEP_3:  w = 1'b0;
            STEP_4:  w = 1'b1;
            STEP_5:  w = 1'b0;
            default: w = 1'b0;
        endcase
        return w;
    endfunction

    // One-hot phase decode, bit 0 is phase A.
    function automatic logic [2:0] phase_onehot(input phase_t p);
        logic [2:0] v;
        case (p)
            PHASE_A: v = 3'b001;
            PHASE_B: v = 3'b010;
            PHASE_C: v = 3'b100;
            default: v = 3'b000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/ssc_if.sv
// Valid/ready channel interfaces for the commutator: pin samples in, gate requests out.
// Depends on ssc_pkg for the phase select type.
interface ssc_sample_if;
    logic valid;
    logic ready;
    logic rc_level;
    logic comp_level;

    modport source (output valid, output rc_level, output comp_level, input ready);
    modport sink   (input valid, input rc_level, input comp_level, output ready);
endinterface

interface ssc_gate_if;
    import ssc_pkg::*;

    logic   valid;
    logic   ready;
    logic   high_a;
    logic   high_b;
    logic   high_c;
    logic   low_a;
    logic   low_b;
    logic   low_c;
    phase_t sense_phase;
    logic   throttle_ok;
    logic   first_cycle_pending;

    modport source (output valid, output high_a, output high_b, output high_c,
                    output low_a, output low_b, output low_c, output sense_phase,
                    output throttle_ok, output first_cycle_pending, input ready);
    modport sink   (input valid, input high_a, input high_b, input high_c,
                    input low_a, input low_b, input low_c, input sense_phase,
                    input throttle_ok, input first_cycle_pending, output ready);
endinterface

FILE: rtl/sensorless_six_step_commutator.sv
// Sensorless six-step BLDC commutator: RC pulse timing, PWM and commutation sequencer.
// Depends on ssc_pkg and the channel interfaces in ssc_if.sv.
//
// Usage: the samples channel carries one request per clock tick of the motor controller,
// holding the RC receiver pin level and the back-EMF comparator level. Every accepted
// request produces exactly one request on the gates channel: the six FET on-flags,
// the comparator phase select and the two indicator flags, all showing the state after
// that tick. Configuration is written through cfg_we / cfg_index / cfg_data while both
// channels are quiet.
//
// A request accepted at a clock edge appears on gates right after that edge.
// Throughput is one request per cycle; the single result register is refilled in the same
// cycle it is drained, so samples.ready only drops while a result waits and gates.ready
// is low. A stalled receiver therefore holds back the sample stream without losing ticks.
//
// Reset clears all timing, PWM and commutation state, loads the register defaults and
// raises the first-cycle pending flag; gates is empty after reset, its FET flags not reset.
module sensorless_six_step_commutator #(
    parameter int RC_TIMER_BITS = 16,
    parameter int PWM_BITS      = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  ssc_pkg::cfg_index_t cfg_index,
    input  ssc_pkg::cfg_data_t  cfg_data,
    ssc_sample_if.sink          samples,
    ssc_gate_if.source          gates
);
    import ssc_pkg::*;

    localparam int CMP_W = (RC_TIMER_BITS > RC_CFG_W) ? RC_TIMER_BITS : RC_CFG_W;
    localparam logic [PWM_BITS-1:0] PWM_MAX = '1;

    // Configuration registers.
    logic [RC_CFG_W-1:0]       rc_min_reg;
    logic [RC_CFG_W-1:0]       rc_max_reg;
    logic [SHIFT_W-1:0]        duty_shift_reg;
    logic [FLOOR_W-1:0]        duty_floor_reg;
    logic [PRESCALE_CFG_W-1:0] pwm_prescale_reg;

    // Block state.
    logic [RC_TIMER_BITS-1:0] tick_count_reg, tick_count_next;
    logic [RC_TIMER_BITS-1:0] rise_time_reg, rise_time_next;
    logic [RC_TIMER_BITS-1:0] pulse_width_reg, pulse_width_next;
    logic                     rc_prev_reg;
    step_t                    step_reg, step_next;
    logic                     running_reg, running_next;
    logic [PWM_BITS-1:0]      duty_reg, duty_next;
    logic [PWM_BITS-1:0]      pwm_count_reg, pwm_count_next;
    logic [PRESCALE_W-1:0]    prescale_count_reg, prescale_count_next;
    logic                     low_enable_reg, low_enable_next;
    logic                     red_flag_reg, red_flag_next;

    typedef struct packed {
        logic [2:0] high;
        logic [2:0] low;
        phase_t     sense;
        logic       throttle_ok;
        logic       first_pending;
    } result_t;

    result_t result_reg, result_next;
    logic    out_valid_reg, out_valid_next;
    logic    accept;

    logic [PRESCALE_CFG_W-1:0] prescale_clamped;
    logic [PRESCALE_W-1:0]     prescale_top;
    logic [CMP_W-1:0]          width_w;
    logic [CMP_W-1:0]          excess;
    logic [CMP_W-1:0]          duty_wide;
    logic                      window_ok;
    logic                      advance;

    assign samples.ready = !out_valid_reg || gates.ready;
    assign accept        = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_min_reg       <= RC_MIN_RESET;
            rc_max_reg       <= RC_MAX_RESET;
            duty_shift_reg   <= DUTY_SHIFT_RESET;
            duty_floor_reg   <= DUTY_FLOOR_RESET;
            pwm_prescale_reg <= PWM_PRESCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RC_MIN:       rc_min_reg       <= cfg_data[RC_CFG_W-1:0];
                CFG_RC_MAX:       rc_max_reg       <= cfg_data[RC_CFG_W-1:0];
                CFG_DUTY_SHIFT:   duty_shift_reg   <= cfg_data[SHIFT_W-1:0];
                CFG_DUTY_FLOOR:   duty_floor_reg   <= cfg_data[FLOOR_W-1:0];
                CFG_PWM_PRESCALE: pwm_prescale_reg <= cfg_data[PRESCALE_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Prescale of zero runs every tick; anything above the 8-bit counter range is capped.
    always_comb
    begin
        if (pwm_prescale_reg == '0)
            prescale_clamped = PRESCALE_CFG_W'(1);
        else if (pwm_prescale_reg > PRESCALE_CFG_W'(PRESCALE_MAX))
            prescale_clamped = PRESCALE_CFG_W'(PRESCALE_MAX);
        else
            prescale_clamped = pwm_prescale_reg;
        prescale_top = PRESCALE_W'(prescale_clamped - PRESCALE_CFG_W'(1));
    end

    // Throttle window and duty, both taken from the width as updated by this tick.
    always_comb
    begin
        width_w   = CMP_W'(pulse_width_next);
        window_ok = (width_w >= CMP_W'(rc_min_reg)) && (width_w <= CMP_W'(rc_max_reg));
        excess    = (width_w - CMP_W'(rc_min_reg)) >> duty_shift_reg;
        duty_wide = (excess < CMP_W'(duty_floor_reg)) ? CMP_W'(duty_floor_reg) : excess;
    end

    always_comb
    begin
        tick_count_next     = tick_count_reg;
        rise_time_next      = rise_time_reg;
        pulse_width_next    = pulse_width_reg;
        step_next           = step_reg;
        running_next        = running_reg;
        duty_next           = duty_reg;
        pwm_count_next      = pwm_count_reg;
        prescale_count_next = prescale_count_reg;
        low_enable_next     = low_enable_reg;
        red_flag_next       = red_flag_reg;
        advance             = 1'b0;

        // Edges are timed with the count before it moves on.
        if (samples.rc_level && !rc_prev_reg)
            rise_time_next = tick_count_reg;
        else if (!samples.rc_level && rc_prev_reg)
            pulse_width_next = tick_count_reg - rise_time_reg;
        tick_count_next = tick_count_reg + RC_TIMER_BITS'(1);

        if (prescale_count_reg >= prescale_top)
        begin
            prescale_count_next = '0;
            pwm_count_next      = pwm_count_reg + PWM_BITS'(1);
            // Off at the duty compare wins over on at the wrap, so zero duty stays off.
            if (pwm_count_next == '0)
                low_enable_next = 1'b1;
            if (pwm_count_next == duty_reg)
                low_enable_next = 1'b0;
        end
        else
        begin
            prescale_count_next = prescale_count_reg + PRESCALE_W'(1);
        end

        advance = running_reg && (samples.comp_level == step_wait(step_reg));
        if (advance)
        begin
            if (step_reg == STEP_LAST)
            begin
                running_next  = 1'b0;
                step_next     = STEP_0;
                red_flag_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + step_t'(1);
            end
        end

        if (!running_next && window_ok)
        begin
            duty_next           = (duty_wide > CMP_W'(PWM_MAX)) ? PWM_MAX
                                                                : PWM_BITS'(duty_wide);
            running_next        = 1'b1;
            step_next           = STEP_0;
            pwm_count_next      = '0;
            prescale_count_next = '0;
        end

        result_next.high          = '0;
        result_next.low           = '0;
        result_next.sense         = PHASE_A;
        result_next.throttle_ok   = running_next;
        result_next.first_pending = red_flag_next;
        if (running_next)
        begin
            result_next.high  = phase_onehot(step_high(step_next));
            result_next.low   = low_enable_next ? phase_onehot(step_low(step_next)) : 3'b000;
            result_next.sense = step_sense(step_next);
        end

        if (accept)
            out_valid_next = 1'b1;
        else if (gates.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg     <= '0;
            rise_time_reg      <= '0;
            pulse_width_reg    <= '0;
            rc_prev_reg        <= 1'b0;
            step_reg           <= STEP_0;
            running_reg        <= 1'b0;
            duty_reg           <= '0;
            pwm_count_reg      <= '0;
            prescale_count_reg <= '0;
            low_enable_reg     <= 1'b0;
            red_flag_reg       <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                tick_count_reg     <= tick_count_next;
                rise_time_reg      <= rise_time_next;
                pulse_width_reg    <= pulse_width_next;
                rc_prev_reg        <= samples.rc_level;
                step_reg           <= step_next;
                running_reg        <= running_next;
                duty_reg           <= duty_next;
                pwm_count_reg      <= pwm_count_next;
                prescale_count_reg <= prescale_count_next;
                low_enable_reg     <= low_enable_next;
                red_flag_reg       <= red_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign gates.valid               = out_valid_reg;
    assign gates.high_a              = result_reg.high[0];
    assign gates.high_b              = result_reg.high[1];
    assign gates.high_c              = result_reg.high[2];
    assign gates.low_a               = result_reg.low[0];
    assign gates.low_b               = result_reg.low[1];
    assign gates.low_c               = result_reg.low[2];
    assign gates.sense_phase         = result_reg.sense;
    assign gates.throttle_ok         = result_reg.throttle_ok;
    assign gates.first_cycle_pending = result_reg.first_pending;

    // The sequencer never leaves the six defined steps.
    assert property (@(posedge clk) disable iff (!rst_n) step_reg <= STEP_LAST)
        else $error("commutation step out of range");

    // Once a full rotation has completed, the pending flag never returns.
    assert property (@(posedge clk) disable iff (!rst_n) !red_flag_reg |=> !red_flag_reg)
        else $error("first-cycle flag raised again");

    // No shoot-through: at most one high side, and never both FETs of one phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        gates.valid |-> $onehot0({gates.high_a, gates.high_b, gates.high_c})
            && !(gates.high_a && gates.low_a) && !(gates.high_b && gates.low_b)
            && !(gates.high_c && gates.low_c))
        else $error("conflicting gate drive");

    // Without a running cycle every FET is off and the select rests on phase A.
    assert property (@(posedge clk) disable iff (!rst_n)
        (gates.valid && !gates.throttle_ok) |->
            !(gates.high_a || gates.high_b || gates.high_c
              || gates.low_a || gates.low_b || gates.low_c)
            && gates.sense_phase == PHASE_A)
        else $error("FET driven while idle");

endmodule
